### sv/mbps_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte pattern search: shared definitions
// Widths, codes and the control bundles that the top level hands to the
// matcher cells and the history line.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned MAX_PATTERN_BYTES_DEF = 128;
  localparam int unsigned OFFSET_BITS_DEF       = 25;

  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned ENTRY_BITS    = 7;
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  // Width of one AND group in the match reduction
  localparam int unsigned GROUP_BITS = 16;

  // Request kinds on the input channel
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  // Register word index (paddr[2])
  localparam logic REG_PATTERN_LENGTH = 1'b0;

  // Window movement for one cycle
  typedef struct packed {
    logic                 down;  // move bytes toward older positions
    logic                 up;    // move bytes toward newer positions
    logic                 ins;   // a data byte enters at the insert cell
    logic [BYTE_BITS-1:0] data;
  } mbps_shift_t;

  // Pattern entry write
  typedef struct packed {
    logic                  en;
    logic [ENTRY_BITS-1:0] idx;
    logic [BYTE_BITS-1:0]  pat;
    logic [BYTE_BITS-1:0]  mask;
  } mbps_wr_t;

endpackage

### sv/mbps_cell.sv
// ----------------------------------------------------------------------------
// Matcher cell
// Holds one pattern entry, its mask and one window byte. The window byte
// moves to a neighbor cell each cycle the window shifts; the masked compare
// result is registered for the reduction tree.
// ----------------------------------------------------------------------------
module mbps_cell import mbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int unsigned J                 = 0,
  localparam int unsigned LW               = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  logic                 clk,
  input  logic                 adv,
  input  mbps_shift_t          shift,
  input  mbps_wr_t             wr,
  input  logic [LW-1:0]        len,
  input  logic [BYTE_BITS-1:0] from_above,
  input  logic [BYTE_BITS-1:0] from_below,
  output logic [BYTE_BITS-1:0] win_o,
  output logic                 ok_o
);

  logic [BYTE_BITS-1:0] win_r;
  logic [BYTE_BITS-1:0] pat_r;
  logic [BYTE_BITS-1:0] mask_r;
  logic                 ok_r;
  logic                 ins_here;
  logic                 beyond_len;

  // New byte lands in the cell of the last pattern index
  assign ins_here   = shift.ins && (32'(len) == J + 32'd1);
  assign beyond_len = (J >= 32'(len));

  // Shift the window byte
  always_ff @(posedge clk) begin
    if (shift.down) begin
      win_r <= ins_here ? shift.data : from_above;
    end else if (shift.up) begin
      win_r <= from_below;
    end
  end

  // Load pattern entry
  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.idx) == J)) begin
      pat_r  <= wr.pat;
      mask_r <= wr.mask;
    end
  end

  // Register masked compare; entries past the length always pass
  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r <= beyond_len || ((win_r & mask_r) == pat_r);
    end
  end

  assign win_o = win_r;
  assign ok_o  = ok_r;

endmodule

### sv/mbps_hist.sv
// ----------------------------------------------------------------------------
// Window history line
// Older window bytes below the matcher cells. Keeps enough history that the
// window can be realigned to any pattern length without losing bytes.
// ----------------------------------------------------------------------------
module mbps_hist import mbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
  input  logic                 clk,
  input  mbps_shift_t          shift,
  input  logic [BYTE_BITS-1:0] top_in,
  output logic [BYTE_BITS-1:0] top_out
);

  localparam int unsigned DEPTH = MAX_PATTERN_BYTES - 1;

  logic [BYTE_BITS-1:0] hist_r [DEPTH];

  for (genvar p = 0; p < DEPTH; p++) begin : g_slot
    logic [BYTE_BITS-1:0] above;
    logic [BYTE_BITS-1:0] below;

    if (p == DEPTH - 1) begin : g_top
      assign above = top_in;
    end else begin : g_mid
      assign above = hist_r[p+1];
    end

    if (p == 0) begin : g_bot
      assign below = hist_r[0];
    end else begin : g_low
      assign below = hist_r[p-1];
    end

    // Shift one slot per window move
    always_ff @(posedge clk) begin
      if (shift.down) begin
        hist_r[p] <= above;
      end else if (shift.up) begin
        hist_r[p] <= below;
      end
    end
  end

  assign top_out = hist_r[DEPTH-1];

endmodule

### sv/mbps_reduce.sv
// ----------------------------------------------------------------------------
// Match reduction stage
// ANDs the per-cell compare flags in fixed-size groups and registers the
// group results; the top level finishes the AND over the groups.
// ----------------------------------------------------------------------------
module mbps_reduce import mbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  localparam int unsigned NG = (MAX_PATTERN_BYTES + GROUP_BITS - 1) / GROUP_BITS
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [MAX_PATTERN_BYTES-1:0] ok_i,
  output logic [NG-1:0]                grp_o
);

  logic [NG*GROUP_BITS-1:0] ok_pad;
  logic [NG-1:0]            grp_r;

  // Pad missing flags with pass
  always_comb begin
    ok_pad                          = '1;
    ok_pad[MAX_PATTERN_BYTES-1:0]   = ok_i;
  end

  // Register group ANDs
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < NG; g++) begin
        grp_r[g] <= &ok_pad[g*GROUP_BITS +: GROUP_BITS];
      end
    end
  end

  assign grp_o = grp_r;

endmodule

### sv/masked_byte_pattern_search_top.sv
// Pipeline: a data request passes the window shift, cell compare, group AND
// and output registers before its result is presented.
// Throughput: one request per clock unless the output stalls or a realign
// runs; a new pattern_length realigns the window one byte per cycle with in_ready low.
// Reset: synchronous, clears control state and sets pattern_length to 1;
// pattern and mask entries hold no value until loaded, no clearing pass.
// ----------------------------------------------------------------------------
// Masked byte pattern search top level
// Chain of matcher cells: each cell holds a pattern entry and one window
// byte, compares under its mask and hands the byte to its neighbor as the
// stream advances. Reports the first match offset or a miss at buffer end.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_top import mbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int unsigned OFFSET_BITS       = OFFSET_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  logic [ENTRY_BITS-1:0]    in_entry_index,
  input  logic [BYTE_BITS-1:0]     in_pattern_byte,
  input  logic [BYTE_BITS-1:0]     in_mask_byte,
  input  logic [BYTE_BITS-1:0]     in_data_byte,
  input  logic                     in_last,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic [OFFSET_BITS-1:0]   out_match_offset,
  // Configuration port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  localparam int unsigned LW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned NG = (MAX_PATTERN_BYTES + GROUP_BITS - 1) / GROUP_BITS;
  localparam int unsigned SW = ((OFFSET_BITS >= LW) ? OFFSET_BITS : LW) + 1;

  typedef struct packed {
    logic v;
    logic last;
    logic fill_ok;
  } side_t;

  // Configuration and alignment
  logic [BYTE_BITS-1:0]   len_cfg_r;
  logic [LW-1:0]          eff_len;
  logic [LW-1:0]          align_len_r;
  logic                   realign;
  logic                   realign_up;

  // Handshake and control
  logic                   in_acc;
  logic                   data_acc;
  logic                   load_acc;
  logic                   adv;
  mbps_shift_t            shift;
  mbps_wr_t               wr;

  // Cell chain
  logic [BYTE_BITS-1:0]         cell_win [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_ok;
  logic [BYTE_BITS-1:0]         hist_top;
  logic [NG-1:0]                grp;

  // Stream counters
  logic [LW-1:0]          fill_r;
  logic [LW-1:0]          fill_inc;
  logic [OFFSET_BITS-1:0] pos_r;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [SW-1:0]          start_wide;

  // Pipeline sideband
  side_t                  s0_r, s1_r, s2_r, s0_nxt;
  logic [OFFSET_BITS-1:0] s0_start_r, s1_start_r, s2_start_r;

  // Tail and output
  logic                   match;
  logic                   tail_emit;
  logic                   seen_r;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [OFFSET_BITS-1:0] out_offset_r;

  // Register write and read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= BYTE_BITS'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_PATTERN_LENGTH)) begin
      len_cfg_r <= cfg_pwdata[BYTE_BITS-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_PATTERN_LENGTH) ?
                      CFG_DATA_BITS'(len_cfg_r) : '0;

  // Clamp the length into 1..MAX_PATTERN_BYTES
  always_comb begin
    if (len_cfg_r == '0) begin
      eff_len = LW'(1);
    end else if (32'(len_cfg_r) > MAX_PATTERN_BYTES) begin
      eff_len = LW'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = LW'(len_cfg_r);
    end
  end

  assign realign    = (align_len_r != eff_len);
  assign realign_up = (eff_len > align_len_r);

  // Step the window alignment toward the configured length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_len_r <= LW'(1);
    end else if (realign) begin
      align_len_r <= realign_up ? align_len_r + LW'(1) : align_len_r - LW'(1);
    end
  end

  // Accept requests
  assign in_ready = adv && !realign;
  assign in_acc   = in_valid && in_ready;
  assign data_acc = in_acc && (in_action == ACT_DATA);
  assign load_acc = in_acc && (in_action == ACT_LOAD);

  always_comb begin
    shift.down = data_acc || (realign && !realign_up);
    shift.up   = realign && realign_up;
    shift.ins  = data_acc;
    shift.data = in_data_byte;
    wr.en      = load_acc;
    wr.idx     = in_entry_index;
    wr.pat     = in_pattern_byte;
    wr.mask    = in_mask_byte;
  end

  // Matcher cells
  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
    logic [BYTE_BITS-1:0] above;
    logic [BYTE_BITS-1:0] below;

    if (j == MAX_PATTERN_BYTES - 1) begin : g_top
      assign above = cell_win[j];
    end else begin : g_mid
      assign above = cell_win[j+1];
    end

    if (j == 0) begin : g_bot
      assign below = hist_top;
    end else begin : g_low
      assign below = cell_win[j-1];
    end

    mbps_cell #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .J                 (j)
    ) u_cell (
      .clk        (clk),
      .adv        (adv),
      .shift      (shift),
      .wr         (wr),
      .len        (align_len_r),
      .from_above (above),
      .from_below (below),
      .win_o      (cell_win[j]),
      .ok_o       (cell_ok[j])
    );
  end

  // Older bytes below cell 0
  if (MAX_PATTERN_BYTES > 1) begin : g_hist
    mbps_hist #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_hist (
      .clk     (clk),
      .shift   (shift),
      .top_in  (cell_win[0]),
      .top_out (hist_top)
    );
  end else begin : g_nohist
    assign hist_top = cell_win[0];
  end

  mbps_reduce #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_reduce (
    .clk   (clk),
    .adv   (adv),
    .ok_i  (cell_ok),
    .grp_o (grp)
  );

  // Saturating fill count and byte position
  assign fill_inc   = (fill_r == LW'(MAX_PATTERN_BYTES)) ? fill_r : fill_r + LW'(1);
  assign pos_inc    = (pos_r == '1) ? pos_r : pos_r + OFFSET_BITS'(1);
  assign start_wide = SW'(pos_r) + SW'(1) - SW'(align_len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pos_r  <= '0;
    end else if (data_acc) begin
      fill_r <= in_last ? '0 : fill_inc;
      pos_r  <= in_last ? '0 : pos_inc;
    end
  end

  // Sideband for the byte entering the window
  always_comb begin
    s0_nxt.v       = data_acc;
    s0_nxt.last    = in_last;
    s0_nxt.fill_ok = (fill_inc >= align_len_r);
  end

  // Advance the sideband with the compare pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '0;
      s1_r <= '0;
      s2_r <= '0;
    end else if (adv) begin
      s0_r <= s0_nxt;
      s1_r <= s0_r;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_start_r <= OFFSET_BITS'(start_wide);
      s1_start_r <= s0_start_r;
      s2_start_r <= s1_start_r;
    end
  end

  // Finish the match and decide whether the tail byte produces a result
  assign match     = s2_r.fill_ok && (&grp);
  assign tail_emit = s2_r.v && !seen_r && (match || s2_r.last);
  assign adv       = !(out_valid_r && !out_ready && tail_emit);

  // Track first match within the buffer; drop later matches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (adv && s2_r.v) begin
      seen_r <= s2_r.last ? 1'b0 : (seen_r || match);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && tail_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_emit) begin
      out_found_r  <= match;
      out_offset_r <= match ? s2_start_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_offset_r;

`ifndef NO_ASSERTIONS
  a_miss_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_offset == '0)
    else $error("miss result carries a nonzero offset");

  a_last_clears_seen: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s2_r.v && s2_r.last |=> !seen_r)
    else $error("end of buffer did not clear match state");

  a_match_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
    adv && tail_emit && match && !s2_r.last |=> seen_r && out_valid && out_found)
    else $error("first match not recorded");
`endif

endmodule
